FILE: rtl/euler_rot_trans_scale_matrix_assert.svh
// Assertion macros for the Euler rotation, translation and scale matrix block.
`ifndef EULER_ROT_TRANS_SCALE_MATRIX_ASSERT_SVH
`define EULER_ROT_TRANS_SCALE_MATRIX_ASSERT_SVH
`ifndef SYNTHESIS
`define ERTS_ASSERT_SAME(lbl, clk, rst, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define ERTS_ASSERT_NEXT(lbl, clk, rst, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`else
`define ERTS_ASSERT_SAME(lbl, clk, rst, a, c, msg)
`define ERTS_ASSERT_NEXT(lbl, clk, rst, a, c, msg)
`endif
`endif

FILE: rtl/erts_pkg.sv
// Types and constants for the Euler rotation, translation and scale matrix block.
package erts_pkg;

  localparam int CORDIC_STEPS = 30;
  localparam int CW = 34;
  localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;

  localparam logic signed [CW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756, 34'sd42667331,
    34'sd21354465, 34'sd10679838, 34'sd5340245, 34'sd2670163, 34'sd1335087,
    34'sd667544, 34'sd333772, 34'sd166886, 34'sd83443, 34'sd41722,
    34'sd20861, 34'sd10430, 34'sd5215, 34'sd2608, 34'sd1304,
    34'sd652, 34'sd326, 34'sd163, 34'sd81, 34'sd41,
    34'sd20, 34'sd10, 34'sd5, 34'sd3, 34'sd1
  };

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 neg;
  } cordic_t;

  typedef struct packed {
    logic [15:0]        angle_x;
    logic [15:0]        angle_y;
    logic [15:0]        angle_z;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
  } item_t;

  typedef struct packed {
    logic signed [31:0] row0_col0;
    logic signed [31:0] row0_col1;
    logic signed [31:0] row0_col2;
    logic signed [31:0] row1_col0;
    logic signed [31:0] row1_col1;
    logic signed [31:0] row1_col2;
    logic signed [31:0] row2_col0;
    logic signed [31:0] row2_col1;
    logic signed [31:0] row2_col2;
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;
  } result_t;

endpackage

FILE: rtl/euler_rot_trans_scale_matrix.sv
// Top level: Euler angles, position and scales to a scaled rotation matrix and translation.
// An accepted item passes 30 CORDIC cells and 5 matrix/scale stages before its result is valid.
// Throughput: one item per cycle; the whole pipeline holds while a result is stalled.
// The 30-cell CORDIC row per angle sets the depth; the product stages add five.
// Reset clears only the stage valid bits; data registers are not reset.
module euler_rot_trans_scale_matrix #(
  parameter int ANGLE_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  erts_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output erts_pkg::result_t result
);

  `include "euler_rot_trans_scale_matrix_assert.svh"

  localparam int NS  = erts_pkg::CORDIC_STEPS;
  localparam int TW  = FRAC_BITS + 2;
  localparam int MW  = TW + 1;
  localparam int PW  = MW + 32;
  localparam int LAT = NS + 5;
  localparam logic signed [PW-1:0] PHALF = PW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [PW-1:0] SMAX  = (PW'(1) <<< 31) - PW'(1);
  localparam logic signed [PW-1:0] SMIN  = -(PW'(1) <<< 31);

  logic              en;
  logic [LAT-1:0]    vld;
  erts_pkg::item_t   pay [NS+4];
  erts_pkg::cordic_t seed [3];
  erts_pkg::cordic_t chain [3][NS];
  logic signed [MW-1:0] m [9];
  logic signed [PW-1:0] prod [9];
  logic signed [31:0]   sat [9];

  assign en           = !(vld[LAT-1] && result_stall);
  assign item_stall   = !en;
  assign result_valid = vld[LAT-1];

  function automatic erts_pkg::cordic_t prep(input logic [15:0] ang);
    logic [31:0]       a;
    erts_pkg::cordic_t c;
    a     = 32'(ang) << (32 - ANGLE_BITS);
    c.neg = a[31] ^ a[30];
    if (c.neg) begin
      a[31] = ~a[31];
    end
    c.x = erts_pkg::CORDIC_X0;
    c.y = '0;
    c.z = {{(erts_pkg::CW-32){a[31]}}, a};
    return c;
  endfunction

  assign seed[0] = prep(item.angle_x);
  assign seed[1] = prep(item.angle_y);
  assign seed[2] = prep(item.angle_z);

  for (genvar g = 0; g < 3; g++) begin : g_axis
    for (genvar s = 0; s < NS; s++) begin : g_step
      if (s == 0) begin : g_first
        erts_cell #(.STEP(s)) u_cell (.clk(clk), .en(en), .cin(seed[g]), .cout(chain[g][s]));
      end else begin : g_next
        erts_cell #(.STEP(s)) u_cell (
          .clk(clk), .en(en), .cin(chain[g][s-1]), .cout(chain[g][s])
        );
      end
    end
  end

  erts_matrix #(.FRAC_BITS(FRAC_BITS)) u_matrix (
    .clk(clk), .en(en),
    .ax(chain[0][NS-1]), .ay(chain[1][NS-1]), .az(chain[2][NS-1]),
    .m(m)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], item_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pay[0] <= item;
      for (int k = 1; k < NS + 4; k++) begin
        pay[k] <= pay[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        if (k < 3) begin
          prod[k] <= m[k] * pay[NS+2].scale_x;
        end else if (k < 6) begin
          prod[k] <= m[k] * pay[NS+2].scale_y;
        end else begin
          prod[k] <= m[k] * pay[NS+2].scale_z;
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      logic signed [PW-1:0] r;
      r = (prod[k] + PHALF) >>> FRAC_BITS;
      if (r > SMAX) begin
        r = SMAX;
      end else if (r < SMIN) begin
        r = SMIN;
      end
      sat[k] = r[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.row0_col0 <= sat[0];
      result.row0_col1 <= sat[1];
      result.row0_col2 <= sat[2];
      result.row1_col0 <= sat[3];
      result.row1_col1 <= sat[4];
      result.row1_col2 <= sat[5];
      result.row2_col0 <= sat[6];
      result.row2_col1 <= sat[7];
      result.row2_col2 <= sat[8];
      result.trans_x   <= pay[NS+3].pos_x;
      result.trans_y   <= pay[NS+3].pos_y;
      result.trans_z   <= pay[NS+3].pos_z;
    end
  end

  `ERTS_ASSERT_NEXT(a_accept_enters, clk, rst, item_valid && !item_stall, vld[0],
    "accepted item lost at entry")
  `ERTS_ASSERT_NEXT(a_stall_freezes, clk, rst, result_valid && result_stall, $stable(vld),
    "pipeline moved while stalled")
  `ERTS_ASSERT_NEXT(a_trans_pass, clk, rst, vld[LAT-2] && en,
    result.trans_x == $past(pay[NS+3].pos_x), "translation mismatch")
  `ERTS_ASSERT_SAME(a_stall_src, clk, rst, item_stall, result_valid && result_stall,
    "input stalled without output stall")

endmodule

FILE: rtl/erts_cell.sv
// One CORDIC rotation cell: a single micro-rotation, registered.
module erts_cell #(
  parameter int STEP = 0
) (
  input  logic              clk,
  input  logic              en,
  input  erts_pkg::cordic_t cin,
  output erts_pkg::cordic_t cout
);

  logic signed [erts_pkg::CW-1:0] dx;
  logic signed [erts_pkg::CW-1:0] dy;
  erts_pkg::cordic_t              nxt;

  always_comb begin
    dx  = cin.x >>> STEP;
    dy  = cin.y >>> STEP;
    nxt = cin;
    if (!cin.z[erts_pkg::CW-1]) begin
      nxt.x = cin.x - dy;
      nxt.y = cin.y + dx;
      nxt.z = cin.z - erts_pkg::ATAN_TAB[STEP];
    end else begin
      nxt.x = cin.x + dy;
      nxt.y = cin.y - dx;
      nxt.z = cin.z + erts_pkg::ATAN_TAB[STEP];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cout <= nxt;
    end
  end

endmodule

FILE: rtl/erts_matrix.sv
// Sine/cosine rounding and the three-stage rotation matrix product network.
module erts_matrix #(
  parameter int FRAC_BITS = 16,
  localparam int TW = FRAC_BITS + 2,
  localparam int MW = TW + 1
) (
  input  logic                 clk,
  input  logic                 en,
  input  erts_pkg::cordic_t    ax,
  input  erts_pkg::cordic_t    ay,
  input  erts_pkg::cordic_t    az,
  output logic signed [MW-1:0] m [9]
);

  localparam int CW  = erts_pkg::CW;
  localparam int PW2 = 2 * TW;
  localparam logic signed [CW-1:0]  RHALF = CW'(1) <<< (29 - FRAC_BITS);
  localparam logic signed [CW-1:0]  ONE   = CW'(1) <<< FRAC_BITS;
  localparam logic signed [PW2-1:0] PHALF = PW2'(1) <<< (FRAC_BITS - 1);

  function automatic logic signed [TW-1:0] rnd(input logic signed [erts_pkg::CW-1:0] v,
                                               input logic neg);
    logic signed [erts_pkg::CW-1:0] r;
    logic signed [TW-1:0]           t;
    r = (v + RHALF) >>> (30 - FRAC_BITS);
    if (r > ONE) begin
      r = ONE;
    end else if (r < -ONE) begin
      r = -ONE;
    end
    t = TW'(r);
    return neg ? -t : t;
  endfunction

  function automatic logic signed [TW-1:0] mul(input logic signed [TW-1:0] a,
                                               input logic signed [TW-1:0] b);
    logic signed [2*TW-1:0] p;
    p = a * b + PHALF;
    return TW'(p >>> FRAC_BITS);
  endfunction

  logic signed [TW-1:0] sx, cx, sy, cy, sz, cz;
  logic signed [TW-1:0] szcy, szsy, czcy, czsy, sysx, czcx, cysx, sycx, cycx, czsx;
  logic signed [TW-1:0] sx2, cx2, sz2;

  always_ff @(posedge clk) begin
    if (en) begin
      sx <= rnd(ax.y, ax.neg);
      cx <= rnd(ax.x, ax.neg);
      sy <= rnd(ay.y, ay.neg);
      cy <= rnd(ay.x, ay.neg);
      sz <= rnd(az.y, az.neg);
      cz <= rnd(az.x, az.neg);

      szcy <= mul(sz, cy);
      szsy <= mul(sz, sy);
      czcy <= mul(cz, cy);
      czsy <= mul(cz, sy);
      sysx <= mul(sy, sx);
      czcx <= mul(cz, cx);
      cysx <= mul(cy, sx);
      sycx <= mul(sy, cx);
      cycx <= mul(cy, cx);
      czsx <= mul(cz, sx);
      sx2  <= sx;
      cx2  <= cx;
      sz2  <= sz;

      m[0] <= MW'(czcy);
      m[1] <= MW'(sz2);
      m[2] <= -MW'(czsy);
      m[3] <= MW'(sysx) - MW'(mul(szcy, cx2));
      m[4] <= MW'(czcx);
      m[5] <= MW'(cysx) + MW'(mul(szsy, cx2));
      m[6] <= MW'(sycx) + MW'(mul(szcy, sx2));
      m[7] <= -MW'(czsx);
      m[8] <= MW'(cycx) - MW'(mul(szsy, sx2));
    end
  end

endmodule

FILE: dv/erts_checker.sv
// Checker for the Euler rotation matrix block: predicts each result and compares it.
`timescale 1ns / 100ps
module erts_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_stall,
  input  erts_pkg::item_t   item,
  input  logic              result_valid,
  input  logic              result_stall,
  input  erts_pkg::result_t result,
  output int                errors,
  output int                pending,
  output int                matched
);

  localparam int FB = 16;
  localparam longint ONE = 64'sd1 <<< FB;

  erts_pkg::result_t matrix_q[$];
  int                mismatches = 0;
  int                n_checked = 0;

  function automatic longint mulq(longint a, longint b);
    return (a * b + (64'sd1 <<< (FB - 1))) >>> FB;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void sin_cos(logic [15:0] ang, output longint s, output longint c);
    logic [31:0] a;
    logic        flip;
    longint      x, y, z, dx, dy;
    a = {ang, 16'h0};
    flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
    if (flip) a = a - 32'h8000_0000;
    x = 652032874;
    y = 0;
    z = longint'(signed'(a));
    for (int i = 0; i < erts_pkg::CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(erts_pkg::ATAN_TAB[i]);
      end else begin
        x += dx; y -= dy; z += longint'(erts_pkg::ATAN_TAB[i]);
      end
    end
    x = clip((x + (64'sd1 <<< (29 - FB))) >>> (30 - FB), -ONE, ONE);
    y = clip((y + (64'sd1 <<< (29 - FB))) >>> (30 - FB), -ONE, ONE);
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic signed [31:0] apply_scale(longint e, logic signed [31:0] sc);
    return 32'(clip(mulq(e, longint'(sc)), -64'sd2147483648, 64'sd2147483647));
  endfunction

  function automatic erts_pkg::result_t build_matrix(erts_pkg::item_t it);
    longint sx, cx, sy, cy, sz, cz, szcy, szsy;
    longint m[9];
    erts_pkg::result_t r;
    sin_cos(it.angle_x, sx, cx);
    sin_cos(it.angle_y, sy, cy);
    sin_cos(it.angle_z, sz, cz);
    szcy = mulq(sz, cy);
    szsy = mulq(sz, sy);
    m[0] = mulq(cz, cy);
    m[1] = sz;
    m[2] = -mulq(cz, sy);
    m[3] = mulq(sy, sx) - mulq(szcy, cx);
    m[4] = mulq(cz, cx);
    m[5] = mulq(cy, sx) + mulq(szsy, cx);
    m[6] = mulq(sy, cx) + mulq(szcy, sx);
    m[7] = -mulq(cz, sx);
    m[8] = mulq(cy, cx) - mulq(szsy, sx);
    r.row0_col0 = apply_scale(m[0], it.scale_x);
    r.row0_col1 = apply_scale(m[1], it.scale_x);
    r.row0_col2 = apply_scale(m[2], it.scale_x);
    r.row1_col0 = apply_scale(m[3], it.scale_y);
    r.row1_col1 = apply_scale(m[4], it.scale_y);
    r.row1_col2 = apply_scale(m[5], it.scale_y);
    r.row2_col0 = apply_scale(m[6], it.scale_z);
    r.row2_col1 = apply_scale(m[7], it.scale_z);
    r.row2_col2 = apply_scale(m[8], it.scale_z);
    r.trans_x = it.pos_x;
    r.trans_y = it.pos_y;
    r.trans_z = it.pos_z;
    return r;
  endfunction

  task automatic report(string fname, logic [31:0] exp_v, logic [31:0] act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %0s: expected %h got %h", fname, exp_v, act_v);
  endtask

  assign errors  = mismatches;
  assign matched = n_checked;

  always @(posedge clk) begin
    erts_pkg::result_t want;
    if (!rst) begin
      if (item_valid && !item_stall)
        matrix_q.push_back(build_matrix(item));
      if (result_valid && !result_stall) begin
        if (matrix_q.size() == 0) begin
          report("unexpected result", 0, 0);
        end else begin
          want = matrix_q.pop_front();
          n_checked++;
          if (want.row0_col0 !== result.row0_col0)
            report("row0_col0", want.row0_col0, result.row0_col0);
          if (want.row0_col1 !== result.row0_col1)
            report("row0_col1", want.row0_col1, result.row0_col1);
          if (want.row0_col2 !== result.row0_col2)
            report("row0_col2", want.row0_col2, result.row0_col2);
          if (want.row1_col0 !== result.row1_col0)
            report("row1_col0", want.row1_col0, result.row1_col0);
          if (want.row1_col1 !== result.row1_col1)
            report("row1_col1", want.row1_col1, result.row1_col1);
          if (want.row1_col2 !== result.row1_col2)
            report("row1_col2", want.row1_col2, result.row1_col2);
          if (want.row2_col0 !== result.row2_col0)
            report("row2_col0", want.row2_col0, result.row2_col0);
          if (want.row2_col1 !== result.row2_col1)
            report("row2_col1", want.row2_col1, result.row2_col1);
          if (want.row2_col2 !== result.row2_col2)
            report("row2_col2", want.row2_col2, result.row2_col2);
          if (want.trans_x !== result.trans_x) report("trans_x", want.trans_x, result.trans_x);
          if (want.trans_y !== result.trans_y) report("trans_y", want.trans_y, result.trans_y);
          if (want.trans_z !== result.trans_z) report("trans_z", want.trans_z, result.trans_z);
        end
      end
    end
    pending = matrix_q.size();
  end
endmodule

FILE: dv/tb_euler_rot_trans_scale_matrix.sv
// Testbench top for the Euler rotation matrix block: stimulus, flow control and verdict.
`timescale 1ns / 100ps
module tb_euler_rot_trans_scale_matrix;

  localparam int LIMIT = 400000;
  localparam int N_RANDOM = 1400;

  logic              clk, rst;
  logic              item_valid, item_stall, result_valid;
  logic              result_stall = 1'b0;
  erts_pkg::item_t   item;
  erts_pkg::result_t result;
  int                errors, pending, matched;
  int                cycles = 0;
  int                sent;
  int                stall_mode = 0;

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  euler_rot_trans_scale_matrix u_top (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  erts_checker u_chk (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .errors(errors), .pending(pending), .matched(matched)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  // receiver stall pattern: free, light, heavy, periodic
  always @(negedge clk) begin
    case (stall_mode)
      0: result_stall <= 1'b0;
      1: result_stall <= ($urandom_range(0, 9) == 0);
      2: result_stall <= ($urandom_range(0, 9) < 7);
      default: result_stall <= ((cycles % 7) < 3);
    endcase
  end

  always @(posedge clk)
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);

  function automatic logic signed [31:0] edge_word();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'sh0001_0000;
      3: return -32'sh0001_0000;
      4: return 32'sh0;
      5: return 32'(signed'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
      default: return signed'($urandom());
    endcase
  endfunction

  task automatic send(erts_pkg::item_t it);
    item <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic go_idle(int n);
    item_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic directed(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                          logic signed [31:0] s);
    erts_pkg::item_t it;
    it.angle_x = ax; it.angle_y = ay; it.angle_z = az;
    it.pos_x = signed'($urandom()); it.pos_y = signed'($urandom());
    it.pos_z = signed'($urandom());
    it.scale_x = s; it.scale_y = s; it.scale_z = s;
    send(it);
  endtask

  initial begin
    erts_pkg::item_t it;
    sent = 0;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // quadrant edges, unit/zero/saturating scales, extreme positions
    directed(16'h0000, 16'h0000, 16'h0000, 32'sh0001_0000);
    directed(16'h4000, 16'h8000, 16'hc000, 32'sh0001_0000);
    directed(16'h3fff, 16'h7fff, 16'hbfff, 32'sh0001_0000);
    directed(16'hffff, 16'h4001, 16'h8001, 32'sh0001_0000);
    directed(16'h2000, 16'h6000, 16'ha000, 32'sh0);
    directed(16'h1234, 16'hfedc, 16'h5555, 32'sh7fff_ffff);
    directed(16'h1234, 16'hfedc, 16'h5555, 32'sh8000_0000);
    directed(16'h0000, 16'h4000, 16'h0000, -32'sh0001_0000);
    directed(16'haaaa, 16'h5555, 16'hffff, 32'sh0100_0000);
    it = '0;
    it.pos_x = 32'sh7fff_ffff; it.pos_y = 32'sh8000_0000; it.pos_z = -32'sh1;
    it.scale_x = 32'sh7fff_ffff; it.scale_y = 32'sh8000_0000; it.scale_z = 32'sh0;
    send(it);
    it.angle_x = 16'hffff; it.angle_y = 16'hffff; it.angle_z = 16'hffff;
    it.pos_x = 32'sh8000_0000; it.pos_y = 32'sh7fff_ffff; it.pos_z = 32'sh0;
    it.scale_x = 32'sh8000_0000; it.scale_y = 32'sh7fff_ffff; it.scale_z = 32'sh1;
    send(it);

    // drain once with the sender held off
    go_idle(1);
    while (pending != 0) @(negedge clk);

    for (int n = 0; n < N_RANDOM; ) begin
      int burst;
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst; b++) begin
        it.angle_x = $urandom(); it.angle_y = $urandom(); it.angle_z = $urandom();
        it.pos_x = edge_word(); it.pos_y = edge_word(); it.pos_z = edge_word();
        it.scale_x = edge_word(); it.scale_y = edge_word(); it.scale_z = edge_word();
        send(it);
        n++;
      end
      if ($urandom_range(0, 2) != 0) go_idle($urandom_range(1, 12));
    end
    item_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    $display("sent %0d items, checked %0d results; angles over all quadrants,",
             sent, matched);
    $display("scales and positions at extremes, under random sender gaps and stalls");
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
